>>> sv/crg_pkg.sv
// crg_pkg: shared widths, constants, register codes and pipeline structs
// for the camera ray generator. No dependencies.
package crg_pkg;

    localparam int C_COMP_W          = 20;
    localparam int C_COORD_FRAC_BITS = 12;
    localparam int C_DIR_FRAC_BITS   = 14;
    localparam int C_PROD_FRAC       = 28;
    localparam int C_EXT_FRAC        = C_COORD_FRAC_BITS + C_PROD_FRAC;
    localparam int C_ORG_SHIFT       = C_EXT_FRAC - C_COORD_FRAC_BITS;

    localparam int C_IN_W       = 16;
    localparam int C_ASPECT_W   = 16;
    localparam int C_DIR_W      = 16;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 3 * C_COMP_W;

    localparam int C_SA_W       = C_ASPECT_W + C_IN_W;
    localparam int C_CS_W       = C_COMP_W + C_SA_W;
    localparam int C_RC_W       = C_COMP_W + C_IN_W;
    localparam int C_RC_SHIFT   = C_PROD_FRAC - C_IN_W;
    localparam int C_ACC_W      = 54;
    localparam int C_MAG_W      = C_ACC_W - 1;

    localparam int C_NORM_TOP   = 29;
    localparam int C_NMAG_W     = C_NORM_TOP + 1;
    localparam int C_GRP_W      = 8;
    localparam int C_GRP_N      = (C_MAG_W + C_GRP_W - 1) / C_GRP_W;
    localparam int C_GRP_POS_W  = $clog2(C_GRP_W);
    localparam int C_POS_W      = $clog2(C_GRP_N * C_GRP_W);
    localparam int C_SHIFT_W    = $clog2(C_NORM_TOP + 1);

    localparam int C_SQ_W       = 2 * C_NMAG_W;
    localparam int C_RAD_W      = C_SQ_W + 2;
    localparam int C_ROOT_W     = C_RAD_W / 2;
    localparam int C_SQRT_REM_W = C_ROOT_W + 3;

    localparam logic [C_CFG_IDX_W-1:0] C_REG_EYE    = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_VIEW   = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_COLUMN = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ROW    = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_ASPECT = 3'd4;

    typedef logic [2:0][C_COMP_W-1:0] t_vec3;

    typedef struct packed {
        t_vec3                  eye;
        t_vec3                  view;
        t_vec3                  col;
        t_vec3                  row;
        logic [C_ASPECT_W-1:0]  aspect;
    } t_cam_cfg;

    localparam t_cam_cfg C_CFG_RESET = '{
        eye:    '0,
        view:   '0,
        col:    '0,
        row:    '0,
        aspect: 16'd4096
    };

    typedef struct packed {
        t_vec3                     origin;
        logic [2:0]                neg;
        logic [2:0][C_MAG_W-1:0]   mag;
    } t_front_out;

    typedef struct packed {
        t_vec3       origin;
        logic [2:0]  neg;
        logic        degen;
    } t_ray_side;

    typedef struct packed {
        t_ray_side                 ray;
        logic [2:0][C_NMAG_W-1:0]  mag;
    } t_sqrt_side;

endpackage

>>> sv/crg_front.sv
// crg_front: five-stage affine front end. Forms the view-plane point, the
// rounded and saturated origin, and direction magnitudes and signs. Uses crg_pkg.
module crg_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crg_pkg::t_cam_cfg             i_cfg,
    input  logic                          i_valid,
    input  logic [crg_pkg::C_IN_W-1:0]    i_unit_column,
    input  logic [crg_pkg::C_IN_W-1:0]    i_unit_row,
    output logic                          o_valid,
    output crg_pkg::t_front_out           o_data
);
    localparam int ACC_W = crg_pkg::C_ACC_W;
    localparam int COMP_W = crg_pkg::C_COMP_W;
    localparam int TW = ACC_W - crg_pkg::C_ORG_SHIFT;
    localparam logic signed [TW-1:0] ORG_MAX = {{(TW-COMP_W+1){1'b0}}, {(COMP_W-1){1'b1}}};
    localparam logic signed [TW-1:0] ORG_MIN = {{(TW-COMP_W+1){1'b1}}, {(COMP_W-1){1'b0}}};

    logic                                   r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [crg_pkg::C_SA_W-1:0]             r_sa;
    logic [crg_pkg::C_IN_W-1:0]             r_cw;
    logic [2:0][crg_pkg::C_CS_W-1:0]        r_cs;
    logic [2:0][crg_pkg::C_RC_W-1:0]        r_rc;
    logic [2:0][ACC_W-1:0]                  r_pt;
    logic [2:0][ACC_W-1:0]                  r_dir;
    logic [2:0][ACC_W-1:0]                  r_org;
    crg_pkg::t_front_out                    r_out;

    logic signed [crg_pkg::C_IN_W-1:0]      cu;
    logic signed [crg_pkg::C_IN_W-1:0]      cw;
    logic signed [crg_pkg::C_SA_W:0]        sa_full;
    logic [2:0][crg_pkg::C_CS_W-1:0]        n_cs;
    logic [2:0][crg_pkg::C_RC_W-1:0]        n_rc;
    logic [2:0][ACC_W-1:0]                  n_pt;
    logic [2:0][ACC_W-1:0]                  n_dir;
    logic [2:0][ACC_W-1:0]                  n_org;
    crg_pkg::t_front_out                    n_out;

    // stage 1: centered coordinates, aspect-scaled column offset
    always_comb begin
        cu = $signed({~i_unit_column[crg_pkg::C_IN_W-1], i_unit_column[crg_pkg::C_IN_W-2:0]});
        cw = $signed({~i_unit_row[crg_pkg::C_IN_W-1], i_unit_row[crg_pkg::C_IN_W-2:0]});
        sa_full = $signed({1'b0, i_cfg.aspect}) * cu;
    end

    // stage 2: axis products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cs[i] = $signed(i_cfg.col[i]) * $signed(r_sa);
            n_rc[i] = $signed(i_cfg.row[i]) * $signed(r_cw);
        end
    end

    // stage 3: view-plane point, 40 fraction bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_pt[i] = ({{(ACC_W-COMP_W){i_cfg.view[i][COMP_W-1]}}, i_cfg.view[i]}
                          << crg_pkg::C_PROD_FRAC)
                    + {{(ACC_W-crg_pkg::C_CS_W){r_cs[i][crg_pkg::C_CS_W-1]}}, r_cs[i]}
                    + ({{(ACC_W-crg_pkg::C_RC_W){r_rc[i][crg_pkg::C_RC_W-1]}}, r_rc[i]}
                          << crg_pkg::C_RC_SHIFT);
        end
    end

    // stage 4: direction and origin
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_dir[i] = r_pt[i]
                     - ({{(ACC_W-COMP_W){i_cfg.eye[i][COMP_W-1]}}, i_cfg.eye[i]}
                          << crg_pkg::C_PROD_FRAC);
            n_org[i] = r_pt[i]
                     + ({{(ACC_W-COMP_W){i_cfg.eye[i][COMP_W-1]}}, i_cfg.eye[i]}
                          << crg_pkg::C_PROD_FRAC)
                     - ({{(ACC_W-COMP_W){i_cfg.view[i][COMP_W-1]}}, i_cfg.view[i]}
                          << crg_pkg::C_PROD_FRAC);
        end
    end

    // stage 5: round half up, saturate; sign and magnitude of direction
    always_comb begin
        logic [ACC_W-1:0]        rnd;
        logic signed [TW-1:0]    t;
        logic [ACC_W-1:0]        a;
        n_out = r_out;
        for (int i = 0; i < 3; i++) begin
            rnd = r_org[i] + (ACC_W'(1) << (crg_pkg::C_ORG_SHIFT - 1));
            t = $signed(rnd[ACC_W-1:crg_pkg::C_ORG_SHIFT]);
            if (t > ORG_MAX) begin
                t = ORG_MAX;
            end else if (t < ORG_MIN) begin
                t = ORG_MIN;
            end
            n_out.origin[i] = t[COMP_W-1:0];
            n_out.neg[i] = r_dir[i][ACC_W-1];
            a = r_dir[i][ACC_W-1] ? (~r_dir[i] + 1'b1) : r_dir[i];
            n_out.mag[i] = a[crg_pkg::C_MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sa  <= sa_full[crg_pkg::C_SA_W-1:0];
        r_cw  <= cw;
        r_cs  <= n_cs;
        r_rc  <= n_rc;
        r_pt  <= n_pt;
        r_dir <= n_dir;
        r_org <= n_org;
        r_out <= n_out;
    end

    assign o_valid = r_v5;
    assign o_data  = r_out;

endmodule

>>> sv/crg_norm.sv
// crg_norm: five-stage normalizer. Finds the leading one of the largest
// magnitude, shifts all three to a common scale, squares and sums. Uses crg_pkg.
module crg_norm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  crg_pkg::t_front_out               i_data,
    output logic                              o_valid,
    output logic [crg_pkg::C_RAD_W-1:0]       o_radicand,
    output crg_pkg::t_sqrt_side               o_side
);
    localparam int MAG_W  = crg_pkg::C_MAG_W;
    localparam int NMAG_W = crg_pkg::C_NMAG_W;
    localparam int GRP_N  = crg_pkg::C_GRP_N;
    localparam int GRP_W  = crg_pkg::C_GRP_W;
    localparam int PAD_W  = GRP_N * GRP_W;

    logic                                     r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [2:0][MAG_W-1:0]                    r_mag1, r_mag2;
    crg_pkg::t_ray_side                       r_ray1, r_ray2, r_ray3, r_ray4, r_ray5;
    logic [GRP_N-1:0]                         r_nz;
    logic [GRP_N-1:0][crg_pkg::C_GRP_POS_W-1:0] r_pos;
    logic                                     r_right;
    logic [crg_pkg::C_SHIFT_W-1:0]            r_amt;
    logic [2:0][NMAG_W-1:0]                   r_nmag3, r_nmag4, r_nmag5;
    logic [2:0][crg_pkg::C_SQ_W-1:0]          r_sq;
    logic [crg_pkg::C_RAD_W-1:0]              r_rad;

    logic [GRP_N-1:0]                         n_nz;
    logic [GRP_N-1:0][crg_pkg::C_GRP_POS_W-1:0] n_pos;
    logic                                     n_right;
    logic [crg_pkg::C_SHIFT_W-1:0]            n_amt;
    logic                                     n_degen;
    logic [2:0][NMAG_W-1:0]                   n_nmag;
    logic [2:0][crg_pkg::C_SQ_W-1:0]          n_sq;
    logic [crg_pkg::C_RAD_W-1:0]              n_rad;

    // stage 1: per-group leading one of the OR of the magnitudes
    always_comb begin
        logic [PAD_W-1:0] m;
        m = PAD_W'(i_data.mag[0] | i_data.mag[1] | i_data.mag[2]);
        for (int g = 0; g < GRP_N; g++) begin
            n_nz[g] = |m[g*GRP_W +: GRP_W];
            n_pos[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                if (m[g*GRP_W + b]) begin
                    n_pos[g] = crg_pkg::C_GRP_POS_W'(b);
                end
            end
        end
    end

    // stage 2: top bit position and shift toward bit C_NORM_TOP
    always_comb begin
        logic [crg_pkg::C_POS_W-1:0] p;
        p = '0;
        for (int g = 0; g < GRP_N; g++) begin
            if (r_nz[g]) begin
                p = crg_pkg::C_POS_W'(g * GRP_W) + crg_pkg::C_POS_W'(r_pos[g]);
            end
        end
        n_degen = ~|r_nz;
        n_right = p > crg_pkg::C_NORM_TOP;
        n_amt = n_right ? crg_pkg::C_SHIFT_W'(p - crg_pkg::C_NORM_TOP)
                        : crg_pkg::C_SHIFT_W'(crg_pkg::C_NORM_TOP - p);
    end

    // stage 3: common shift
    always_comb begin
        logic [MAG_W-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            sh = r_right ? (r_mag2[i] >> r_amt) : (r_mag2[i] << r_amt);
            n_nmag[i] = sh[NMAG_W-1:0];
        end
    end

    // stage 4 and 5: squares, then their sum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sq[i] = r_nmag3[i] * r_nmag3[i];
        end
        n_rad = crg_pkg::C_RAD_W'(r_sq[0]) + crg_pkg::C_RAD_W'(r_sq[1])
              + crg_pkg::C_RAD_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag1        <= i_data.mag;
        r_ray1        <= '{origin: i_data.origin, neg: i_data.neg, degen: 1'b0};
        r_nz          <= n_nz;
        r_pos         <= n_pos;
        r_mag2        <= r_mag1;
        r_ray2        <= '{origin: r_ray1.origin, neg: r_ray1.neg, degen: n_degen};
        r_right       <= n_right;
        r_amt         <= n_amt;
        r_nmag3       <= n_nmag;
        r_ray3        <= r_ray2;
        r_sq          <= n_sq;
        r_nmag4       <= r_nmag3;
        r_ray4        <= r_ray3;
        r_rad         <= n_rad;
        r_nmag5       <= r_nmag4;
        r_ray5        <= r_ray4;
    end

    assign o_valid      = r_v5;
    assign o_radicand   = r_rad;
    assign o_side.ray   = r_ray5;
    assign o_side.mag   = r_nmag5;

endmodule

>>> sv/crg_sqrt.sv
// crg_sqrt: pipelined digit-by-digit integer square root, one root bit per
// stage. Carries the direction sideband along. Uses crg_pkg.
module crg_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [crg_pkg::C_RAD_W-1:0]       i_radicand,
    input  crg_pkg::t_sqrt_side               i_side,
    output logic                              o_valid,
    output logic [crg_pkg::C_ROOT_W-1:0]      o_root,
    output crg_pkg::t_sqrt_side               o_side
);
    localparam int STEPS  = crg_pkg::C_ROOT_W;
    localparam int REM_W  = crg_pkg::C_SQRT_REM_W;
    localparam int ROOT_W = crg_pkg::C_ROOT_W;
    localparam int RAD_W  = crg_pkg::C_RAD_W;

    logic                   r_valid [STEPS];
    logic [RAD_W-1:0]       r_rad   [STEPS];
    logic [REM_W-1:0]       r_rem   [STEPS];
    logic [ROOT_W-1:0]      r_root  [STEPS];
    crg_pkg::t_sqrt_side    r_side  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int PAIR = 2 * (STEPS - 1 - k);
        logic                   prev_valid;
        logic [RAD_W-1:0]       prev_rad;
        logic [REM_W-1:0]       prev_rem;
        logic [ROOT_W-1:0]      prev_root;
        crg_pkg::t_sqrt_side    prev_side;
        logic [REM_W-1:0]       cur;
        logic [REM_W-1:0]       trial;
        logic [REM_W-1:0]       n_rem;
        logic [ROOT_W-1:0]      n_root;

        if (k == 0) begin : g_first
            assign prev_valid = i_valid;
            assign prev_rad   = i_radicand;
            assign prev_rem   = '0;
            assign prev_root  = '0;
            assign prev_side  = i_side;
        end else begin : g_next
            assign prev_valid = r_valid[k-1];
            assign prev_rad   = r_rad[k-1];
            assign prev_rem   = r_rem[k-1];
            assign prev_root  = r_root[k-1];
            assign prev_side  = r_side[k-1];
        end

        always_comb begin
            cur   = {prev_rem[REM_W-3:0], prev_rad[PAIR +: 2]};
            trial = REM_W'({prev_root, 2'b01});
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {prev_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {prev_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= prev_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[k]  <= prev_rad;
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_side[k] <= prev_side;
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

>>> sv/crg_div.sv
// crg_div: three-lane pipelined restoring divider, one quotient bit per stage,
// giving round(mag * 2^DIR_FRAC_BITS / len) with ties away from zero. Uses crg_pkg.
module crg_div #(
    parameter int DIR_FRAC_BITS = crg_pkg::C_DIR_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [crg_pkg::C_ROOT_W-1:0]          i_len,
    input  crg_pkg::t_sqrt_side                   i_side,
    output logic                                  o_valid,
    output logic [2:0][DIR_FRAC_BITS:0]           o_quo,
    output crg_pkg::t_ray_side                    o_ray
);
    localparam int QUO_W = DIR_FRAC_BITS + 1;
    localparam int STEPS = QUO_W;
    localparam int LEN_W = crg_pkg::C_ROOT_W;
    localparam int DIV_W = LEN_W + QUO_W + 1;

    logic                           r_valid [STEPS];
    logic [LEN_W-1:0]               r_len   [STEPS];
    logic [2:0][DIV_W-1:0]          r_rem   [STEPS];
    logic [2:0][QUO_W-1:0]          r_quo   [STEPS];
    crg_pkg::t_ray_side             r_ray   [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int J = QUO_W - 1 - k;
        logic                       prev_valid;
        logic [LEN_W-1:0]           prev_len;
        logic [2:0][DIV_W-1:0]      prev_rem;
        logic [2:0][QUO_W-1:0]      prev_quo;
        crg_pkg::t_ray_side         prev_ray;
        logic [DIV_W-1:0]           trial;
        logic [2:0][DIV_W-1:0]      n_rem;
        logic [2:0][QUO_W-1:0]      n_quo;

        if (k == 0) begin : g_first
            assign prev_valid = i_valid;
            assign prev_len   = i_len;
            assign prev_ray   = i_side.ray;
            assign prev_quo   = '0;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign prev_rem[i] = DIV_W'({i_side.mag[i], {DIR_FRAC_BITS{1'b0}}})
                                   + DIV_W'(i_len >> 1);
            end
        end else begin : g_next
            assign prev_valid = r_valid[k-1];
            assign prev_len   = r_len[k-1];
            assign prev_rem   = r_rem[k-1];
            assign prev_quo   = r_quo[k-1];
            assign prev_ray   = r_ray[k-1];
        end

        always_comb begin
            trial = DIV_W'(prev_len) << J;
            for (int i = 0; i < 3; i++) begin
                n_quo[i] = prev_quo[i];
                if (prev_rem[i] >= trial) begin
                    n_rem[i]    = prev_rem[i] - trial;
                    n_quo[i][J] = 1'b1;
                end else begin
                    n_rem[i]    = prev_rem[i];
                    n_quo[i][J] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= prev_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_len[k] <= prev_len;
            r_rem[k] <= n_rem;
            r_quo[k] <= n_quo;
            r_ray[k] <= prev_ray;
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_quo   = r_quo[STEPS-1];
    assign o_ray   = r_ray[STEPS-1];

endmodule

>>> sv/camera_ray_generator_unit.sv
// camera_ray_generator_unit: top level of the pinhole camera ray generator.
// Holds the camera registers; chains crg_front, crg_norm, crg_sqrt and crg_div.
//
// Usage:
//   Input: drive i_unit_column / i_unit_row (unsigned Q0.16) and pulse start.
//   A word is taken at every edge with start high and busy low; busy stays
//   low, so one pixel can enter every cycle.
//   Output: o_strobe is high for one cycle with origin (Q8.12, saturated),
//   unit direction (Q1.14) and o_degenerate. The receiver cannot hold off a
//   word; results leave in input order, one per accepted word.
//   Pipeline: 5 front-end stages, 5 normalizer stages, one square-root stage
//   per root bit (31), one divider stage per quotient bit (DIR_FRAC_BITS + 1)
//   and the output register.
//   Throughput: one ray per cycle.
//   Configuration: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
//   always high. Write only while no pixel is in flight.
//   Reset (i_rst_n low, synchronous): pipeline emptied, camera vectors zero,
//   aspect ratio 1.0.
module camera_ray_generator_unit #(
    parameter int DIR_FRAC_BITS = crg_pkg::C_DIR_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [crg_pkg::C_IN_W-1:0]             i_unit_column,
    input  logic [crg_pkg::C_IN_W-1:0]             i_unit_row,
    output logic                                   o_strobe,
    output logic signed [crg_pkg::C_COMP_W-1:0]    o_origin_x,
    output logic signed [crg_pkg::C_COMP_W-1:0]    o_origin_y,
    output logic signed [crg_pkg::C_COMP_W-1:0]    o_origin_z,
    output logic signed [crg_pkg::C_DIR_W-1:0]     o_dir_x,
    output logic signed [crg_pkg::C_DIR_W-1:0]     o_dir_y,
    output logic signed [crg_pkg::C_DIR_W-1:0]     o_dir_z,
    output logic                                   o_degenerate,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [crg_pkg::C_CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [crg_pkg::C_CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int QUO_W = DIR_FRAC_BITS + 1;
    localparam int DIR_W = crg_pkg::C_DIR_W;
    localparam int SAT_W = (QUO_W > DIR_W + 1) ? QUO_W : DIR_W + 1;
    localparam logic [SAT_W-1:0] POS_LIM = SAT_W'((1 << (DIR_W - 1)) - 1);
    localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(1 << (DIR_W - 1));

    crg_pkg::t_cam_cfg              r_cfg;
    logic                           r_strobe;
    crg_pkg::t_vec3                 r_origin;
    logic [2:0][DIR_W-1:0]          r_dir;
    logic                           r_degen;

    logic                           front_valid;
    crg_pkg::t_front_out            front_data;
    logic                           norm_valid;
    logic [crg_pkg::C_RAD_W-1:0]    norm_rad;
    crg_pkg::t_sqrt_side            norm_side;
    logic                           sqrt_valid;
    logic [crg_pkg::C_ROOT_W-1:0]   sqrt_root;
    crg_pkg::t_sqrt_side            sqrt_side;
    logic                           div_valid;
    logic [2:0][QUO_W-1:0]          div_quo;
    crg_pkg::t_ray_side             div_ray;
    logic [2:0][DIR_W-1:0]          n_dir;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= crg_pkg::C_CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                crg_pkg::C_REG_EYE:    r_cfg.eye    <= i_cfg_data;
                crg_pkg::C_REG_VIEW:   r_cfg.view   <= i_cfg_data;
                crg_pkg::C_REG_COLUMN: r_cfg.col    <= i_cfg_data;
                crg_pkg::C_REG_ROW:    r_cfg.row    <= i_cfg_data;
                crg_pkg::C_REG_ASPECT: r_cfg.aspect <= i_cfg_data[crg_pkg::C_ASPECT_W-1:0];
                default:               r_cfg        <= r_cfg;
            endcase
        end
    end

    crg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (start && !busy),
        .i_unit_column (i_unit_column),
        .i_unit_row    (i_unit_row),
        .o_valid       (front_valid),
        .o_data        (front_data)
    );

    crg_norm u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (front_valid),
        .i_data     (front_data),
        .o_valid    (norm_valid),
        .o_radicand (norm_rad),
        .o_side     (norm_side)
    );

    crg_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (norm_valid),
        .i_radicand (norm_rad),
        .i_side     (norm_side),
        .o_valid    (sqrt_valid),
        .o_root     (sqrt_root),
        .o_side     (sqrt_side)
    );

    crg_div #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sqrt_valid),
        .i_len   (sqrt_root),
        .i_side  (sqrt_side),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_ray   (div_ray)
    );

    // sign, clamp to the 16-bit field, zero for a degenerate ray
    always_comb begin
        logic [SAT_W-1:0] q;
        logic [DIR_W-1:0] m;
        for (int i = 0; i < 3; i++) begin
            q = SAT_W'(div_quo[i]);
            if (div_ray.neg[i]) begin
                q = (q > NEG_LIM) ? NEG_LIM : q;
            end else begin
                q = (q > POS_LIM) ? POS_LIM : q;
            end
            m = q[DIR_W-1:0];
            if (div_ray.degen) begin
                n_dir[i] = '0;
            end else if (div_ray.neg[i]) begin
                n_dir[i] = ~m + 1'b1;
            end else begin
                n_dir[i] = m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_origin <= div_ray.origin;
        r_dir    <= n_dir;
        r_degen  <= div_ray.degen;
    end

    assign o_strobe     = r_strobe;
    assign o_origin_x   = r_origin[0];
    assign o_origin_y   = r_origin[1];
    assign o_origin_z   = r_origin[2];
    assign o_dir_x      = r_dir[0];
    assign o_dir_y      = r_dir[1];
    assign o_dir_z      = r_dir[2];
    assign o_degenerate = r_degen;

endmodule
